// ----- rtl/core/lupi_pkg.sv -----
// Shared types, constants and Q16.16 helpers for the LUP matrix inverse core.
// Used by lupi_div and lup_matrix_inverse_core; no dependencies.
package lupi_pkg;

  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int QUOT_W  = VALUE_W + FRAC_W;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] FIX_ONE = VALUE_W'(1) << FRAC_W;
  localparam logic signed [2*VALUE_W-1:0] FIX_HALF = (2*VALUE_W)'(1) << (FRAC_W - 1);

  localparam int NUM_ST = 34;

  typedef enum logic [NUM_ST-1:0] {
    S_LOAD    = NUM_ST'(1) << 0,
    S_INIT    = NUM_ST'(1) << 1,
    S_PRD     = NUM_ST'(1) << 2,
    S_PCMP    = NUM_ST'(1) << 3,
    S_PSW     = NUM_ST'(1) << 4,
    S_SWA     = NUM_ST'(1) << 5,
    S_SWB     = NUM_ST'(1) << 6,
    S_SWW1    = NUM_ST'(1) << 7,
    S_SWW2    = NUM_ST'(1) << 8,
    S_URD     = NUM_ST'(1) << 9,
    S_UGET    = NUM_ST'(1) << 10,
    S_LRD     = NUM_ST'(1) << 11,
    S_LDIV    = NUM_ST'(1) << 12,
    S_LWAIT   = NUM_ST'(1) << 13,
    S_ERA     = NUM_ST'(1) << 14,
    S_ERB     = NUM_ST'(1) << 15,
    S_EMUL    = NUM_ST'(1) << 16,
    S_ERND    = NUM_ST'(1) << 17,
    S_EWR     = NUM_ST'(1) << 18,
    S_LASTRD  = NUM_ST'(1) << 19,
    S_LASTCHK = NUM_ST'(1) << 20,
    S_YINIT   = NUM_ST'(1) << 21,
    S_MRD     = NUM_ST'(1) << 22,
    S_MMUL    = NUM_ST'(1) << 23,
    S_MRND    = NUM_ST'(1) << 24,
    S_MACC    = NUM_ST'(1) << 25,
    S_YST     = NUM_ST'(1) << 26,
    S_XINIT   = NUM_ST'(1) << 27,
    S_XDRD    = NUM_ST'(1) << 28,
    S_XDIV    = NUM_ST'(1) << 29,
    S_XWAIT   = NUM_ST'(1) << 30,
    S_ORD     = NUM_ST'(1) << 31,
    S_OLD     = NUM_ST'(1) << 32,
    S_OHOLD   = NUM_ST'(1) << 33
  } state_t;

  // a - b, saturated
  function automatic logic signed [VALUE_W-1:0] sat_sub(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    logic signed [VALUE_W:0] d;
    d = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
    if (d[VALUE_W] != d[VALUE_W-1]) begin
      return d[VALUE_W] ? VAL_MIN : VAL_MAX;
    end
    return d[VALUE_W-1:0];
  endfunction

  // full product to Q16.16: round half up, then saturate
  function automatic logic signed [VALUE_W-1:0] qround(
    input logic signed [2*VALUE_W-1:0] p
  );
    logic signed [2*VALUE_W-1:0] s;
    s = (p + FIX_HALF) >>> FRAC_W;
    if (s > (2*VALUE_W)'(VAL_MAX)) return VAL_MAX;
    if (s < (2*VALUE_W)'(VAL_MIN)) return VAL_MIN;
    return s[VALUE_W-1:0];
  endfunction

endpackage

// ----- rtl/core/lup_matrix_inverse_core.sv -----
// Matrix inverse by LU decomposition with partial pivoting, signed Q16.16.
// Top level; depends on lupi_pkg, lupi_ram and lupi_div.
//
// Load n*n words in row-major order on s_*, the last one flagged by
// s_tlast; the core then factors, solves and streams the n*n inverse words
// row-major on m_*, with m_tuser high and all data zero when a zero pivot is
// found. Input is held off from the last word until the final inverse word
// is taken. Every quotient goes through one shared bit-serial divider, and
// every product through the single work-matrix RAM read port. Output
// drains one word at a time, each held on m_* until taken. n comes from
// cfg_wr_data, clamped to 1..MAX_ORDER, and is sampled at the last input word.
module lup_matrix_inverse_core
  import lupi_pkg::*;
#(
  parameter int MAX_ORDER = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,    // matrix_size
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,        // element_value
  input  logic               s_tlast,        // is_last
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VALUE_W-1:0] m_tdata,        // inverse_value
  output logic               m_tlast,        // is_last_res
  output logic               m_tuser         // singular
);

  localparam int IW    = $clog2(MAX_ORDER);
  localparam int NW    = IW + 1;
  localparam int CELLS = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = AW + 1;
  localparam int MW    = IW + NW;

  state_t state;

  logic [3:0]    msize;
  logic [CW-1:0] load_count;
  logic [NW-1:0] n_r;
  logic [IW-1:0] i, j, k, c, pick;
  logic [IW-1:0] pick_val, perm_i_val;
  logic [VALUE_W:0] best;
  logic signed [VALUE_W-1:0] ta, u, l, opa, bval, qm, acc;
  logic signed [2*VALUE_W-1:0] prod;
  logic          singular;
  logic [CW-1:0] kout;
  logic [IW-1:0] perm [MAX_ORDER];
  logic signed [VALUE_W-1:0] vec [MAX_ORDER];

  logic [NW-1:0] n_now;
  logic [CW-1:0] cells_now, cells_r;
  logic [IW-1:0] n_last;
  logic          s_acc;

  logic [IW-1:0] rd_row, rd_col, wr_row, wr_col, perm_idx, vec_idx;
  logic [MW-1:0] rd_lin, wr_lin, res_lin;
  logic          w_we;
  logic [AW-1:0] w_waddr;
  logic signed [VALUE_W-1:0] w_wdata, w_rdata, r_rdata;
  logic [IW-1:0] perm_q;
  logic signed [VALUE_W-1:0] vec_q;
  logic [VALUE_W:0] rd_abs;

  logic          div_start, div_done;
  logic signed [VALUE_W-1:0] div_num, div_den, div_q;

  // pivot bookkeeping: physical row value of the best row seen so far
  logic [IW-1:0] pick_hold;

  // forward (y) or back (x) substitution in the shared multiply loop
  logic fwd;

  always_comb begin
    if (msize == 4'd0) n_now = NW'(1);
    else if (int'(msize) > MAX_ORDER) n_now = NW'(MAX_ORDER);
    else n_now = NW'(msize);
  end

  assign cells_now = CW'(n_now) * CW'(n_now);
  assign cells_r   = CW'(n_r) * CW'(n_r);
  assign n_last    = IW'(n_r - 1'b1);
  assign s_tready  = (state == S_LOAD);
  assign s_acc     = s_tvalid && s_tready;

  assign perm_idx = (state == S_PRD) ? j : i;
  assign perm_q   = perm[perm_idx];
  assign vec_idx  = (state == S_XINIT) ? i : j;
  assign vec_q    = vec[vec_idx];
  assign rd_abs   = w_rdata[VALUE_W-1] ? -{w_rdata[VALUE_W-1], w_rdata}
                                       : {1'b0, w_rdata};

  // work RAM read address
  always_comb begin
    rd_row = '0;
    rd_col = '0;
    unique case (state)
      S_PRD:    begin rd_row = j;      rd_col = i;      end
      S_SWA:    begin rd_row = i;      rd_col = k;      end
      S_SWB:    begin rd_row = pick;   rd_col = k;      end
      S_URD:    begin rd_row = i;      rd_col = i;      end
      S_LRD:    begin rd_row = j;      rd_col = i;      end
      S_ERA:    begin rd_row = i;      rd_col = k;      end
      S_ERB:    begin rd_row = j;      rd_col = k;      end
      S_LASTRD: begin rd_row = n_last; rd_col = n_last; end
      S_MRD:    begin rd_row = i;      rd_col = j;      end
      S_XDRD:   begin rd_row = i;      rd_col = i;      end
      default:  begin rd_row = '0;     rd_col = '0;     end
    endcase
  end

  // work RAM write port
  always_comb begin
    wr_row  = '0;
    wr_col  = '0;
    w_we    = 1'b0;
    w_wdata = s_tdata;
    unique case (state)
      S_LOAD:  begin w_we = s_acc && (load_count < cells_now); end
      S_SWW1:  begin w_we = 1'b1; wr_row = i;    wr_col = k; w_wdata = w_rdata; end
      S_SWW2:  begin w_we = 1'b1; wr_row = pick; wr_col = k; w_wdata = ta; end
      S_LWAIT: begin w_we = div_done; wr_row = j; wr_col = i; w_wdata = div_q; end
      S_EWR:   begin w_we = 1'b1; wr_row = j; wr_col = k; w_wdata = sat_sub(bval, qm); end
      default: begin w_we = 1'b0; end
    endcase
  end

  assign rd_lin  = MW'(rd_row) * MW'(n_r) + MW'(rd_col);
  assign wr_lin  = MW'(wr_row) * MW'(n_r) + MW'(wr_col);
  assign res_lin = MW'(i) * MW'(n_r) + MW'(c);
  assign w_waddr = (state == S_LOAD) ? load_count[AW-1:0] : wr_lin[AW-1:0];

  assign div_start = (state == S_LDIV) || (state == S_XDIV);
  assign div_num   = (state == S_LDIV) ? w_rdata : acc;
  assign div_den   = (state == S_LDIV) ? u : w_rdata;

  lupi_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_work (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (rd_lin[AW-1:0]),
    .rdata (w_rdata)
  );

  lupi_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_result (
    .clk   (clk),
    .we    ((state == S_XWAIT) && div_done),
    .waddr (res_lin[AW-1:0]),
    .wdata (div_q),
    .raddr (kout[AW-1:0]),
    .rdata (r_rdata)
  );

  lupi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      msize      <= 4'd6;
      load_count <= '0;
      n_r        <= NW'(1);
      singular   <= 1'b0;
      kout       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        msize <= cfg_wr_data;
      end
      unique case (state)
        S_LOAD: begin
          if (s_acc) begin
            if (s_tlast) begin
              load_count <= '0;
              n_r        <= n_now;
              state      <= S_INIT;
            end else if (load_count < cells_now) begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_INIT: begin
          for (int t = 0; t < MAX_ORDER; t++) perm[t] <= IW'(t);
          singular <= 1'b0;
          kout     <= '0;
          i        <= '0;
          j        <= '0;
          pick     <= '0;
          best     <= '0;
          state    <= (n_r == NW'(1)) ? S_LASTRD : S_PRD;
        end
        S_PRD: begin
          pick_val <= perm_q;
          if (j == i) perm_i_val <= perm_q;
          state <= S_PCMP;
        end
        S_PCMP: begin
          if (rd_abs > best) begin
            best <= rd_abs;
            pick <= j;
          end
          if (j == n_last) begin
            state <= S_PSW;
          end else begin
            j     <= j + 1'b1;
            state <= S_PRD;
          end
        end
        S_PSW: begin
          if (best == '0) begin
            singular <= 1'b1;
            state    <= S_ORD;
          end else begin
            if (pick != i) begin
              perm[i]    <= pick_hold;
              perm[pick] <= perm_i_val;
            end
            k          <= '0;
            state      <= (pick == i) ? S_URD : S_SWA;
          end
        end
        S_SWA: state <= S_SWB;
        S_SWB: begin
          ta    <= w_rdata;
          state <= S_SWW1;
        end
        S_SWW1: state <= S_SWW2;
        S_SWW2: begin
          if (k == n_last) begin
            state <= S_URD;
          end else begin
            k     <= k + 1'b1;
            state <= S_SWA;
          end
        end
        S_URD: state <= S_UGET;
        S_UGET: begin
          u     <= w_rdata;
          j     <= i + 1'b1;
          state <= S_LRD;
        end
        S_LRD:  state <= S_LDIV;
        S_LDIV: state <= S_LWAIT;
        S_LWAIT: begin
          if (div_done) begin
            l     <= div_q;
            k     <= i + 1'b1;
            state <= S_ERA;
          end
        end
        S_ERA: state <= S_ERB;
        S_ERB: begin
          opa   <= w_rdata;
          state <= S_EMUL;
        end
        S_EMUL: begin
          prod  <= opa * l;
          bval  <= w_rdata;
          state <= S_ERND;
        end
        S_ERND: begin
          qm    <= qround(prod);
          state <= S_EWR;
        end
        S_EWR: begin
          if (k != n_last) begin
            k     <= k + 1'b1;
            state <= S_ERA;
          end else if (j != n_last) begin
            j     <= j + 1'b1;
            state <= S_LRD;
          end else if (IW'(i + 1'b1) == n_last) begin
            state <= S_LASTRD;
          end else begin
            i     <= i + 1'b1;
            j     <= i + 1'b1;
            pick  <= i + 1'b1;
            best  <= '0;
            state <= S_PRD;
          end
        end
        S_LASTRD: state <= S_LASTCHK;
        S_LASTCHK: begin
          if (w_rdata == '0) begin
            singular <= 1'b1;
            state    <= S_ORD;
          end else begin
            c     <= '0;
            i     <= '0;
            state <= S_YINIT;
          end
        end
        S_YINIT: begin
          acc   <= (perm_q == c) ? FIX_ONE : '0;
          j     <= '0;
          state <= (i == '0) ? S_YST : S_MRD;
        end
        S_MRD: state <= S_MMUL;
        S_MMUL: begin
          prod  <= w_rdata * vec_q;
          state <= S_MRND;
        end
        S_MRND: begin
          qm    <= qround(prod);
          state <= S_MACC;
        end
        S_MACC: begin
          acc <= sat_sub(acc, qm);
          if (fwd) begin
            if (j == IW'(i - 1'b1)) begin
              state <= S_YST;
            end else begin
              j     <= j + 1'b1;
              state <= S_MRD;
            end
          end else begin
            if (j == IW'(i + 1'b1)) begin
              state <= S_XDRD;
            end else begin
              j     <= j - 1'b1;
              state <= S_MRD;
            end
          end
        end
        S_YST: begin
          vec[i] <= acc;
          if (i == n_last) begin
            state <= S_XINIT;
          end else begin
            i     <= i + 1'b1;
            state <= S_YINIT;
          end
        end
        S_XINIT: begin
          acc   <= vec_q;
          j     <= n_last;
          state <= (i == n_last) ? S_XDRD : S_MRD;
        end
        S_XDRD: state <= S_XDIV;
        S_XDIV: state <= S_XWAIT;
        S_XWAIT: begin
          if (div_done) begin
            vec[i] <= div_q;
            if (i != '0) begin
              i     <= i - 1'b1;
              state <= S_XINIT;
            end else if (c == n_last) begin
              state <= S_ORD;
            end else begin
              c     <= c + 1'b1;
              state <= S_YINIT;
            end
          end
        end
        S_ORD: state <= S_OLD;
        S_OLD: begin
          m_tdata  <= singular ? '0 : r_rdata;
          m_tlast  <= (kout == cells_r - 1'b1);
          m_tuser  <= singular;
          m_tvalid <= 1'b1;
          state    <= S_OHOLD;
        end
        S_OHOLD: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= S_LOAD;
            end else begin
              kout  <= kout + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PCMP) begin
      if ((rd_abs > best) || (j == i)) pick_hold <= pick_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b1;
    end else if (state == S_YINIT) begin
      fwd <= 1'b1;
    end else if (state == S_XINIT) begin
      fwd <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == S_OHOLD))
    else $error("output valid outside the output hold state");

  assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  assert property (@(posedge clk) disable iff (rst)
    load_count <= CW'(CELLS))
    else $error("load count beyond matrix storage");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_LWAIT || state == S_XWAIT))
    else $error("divider finished with no consumer waiting");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_OHOLD && !m_tready) |=> (state == S_OHOLD && $stable(kout)))
    else $error("output index moved while stalled");

endmodule

// ----- rtl/core/lupi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lupi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lupi_div.sv -----
// Q16.16 divider: (num * 2^16) / den, truncated toward zero, saturated.
// Restoring radix-2, one quotient bit per cycle. Depends on lupi_pkg.
module lupi_div
  import lupi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [VALUE_W-1:0] num,
  input  logic signed [VALUE_W-1:0] den,
  output logic                      done,
  output logic signed [VALUE_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [QUOT_W-1:0]   dvd;
  logic [VALUE_W-1:0]  rem;
  logic [VALUE_W-1:0]  dmag;
  logic                neg;
  logic                dzero;
  logic [VALUE_W:0]    rem_sh;
  logic [VALUE_W:0]    rem_sub;
  logic [VALUE_W-1:0]  nmag;

  assign nmag    = num[VALUE_W-1] ? VALUE_W'(-num) : VALUE_W'(num);
  assign rem_sh  = {rem, dvd[QUOT_W-1]};
  assign rem_sub = rem_sh - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        dvd   <= {nmag, {FRAC_W{1'b0}}};
        rem   <= '0;
        dmag  <= den[VALUE_W-1] ? VALUE_W'(-den) : VALUE_W'(den);
        neg   <= num[VALUE_W-1] ^ den[VALUE_W-1];
        dzero <= (den == '0);
      end else if (busy) begin
        if (!rem_sub[VALUE_W]) begin
          rem <= rem_sub[VALUE_W-1:0];
          dvd <= {dvd[QUOT_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[VALUE_W-1:0];
          dvd <= {dvd[QUOT_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    if (dzero) begin
      quo = '0;
    end else if (neg) begin
      if (dvd > QUOT_W'({1'b1, {(VALUE_W-1){1'b0}}})) quo = VAL_MIN;
      else quo = VALUE_W'(-dvd);
    end else begin
      if (dvd > QUOT_W'(VAL_MAX)) quo = VAL_MAX;
      else quo = dvd[VALUE_W-1:0];
    end
  end

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for lup_matrix_inverse_core: streams Q16.16 matrices in,
// predicts each inverse with a local LUP solver and checks every output word.
// Depends on lupi_pkg and the core RTL.
module tb;
  import lupi_pkg::*;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               sing;
  } inv_word_t;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [3:0]         cfg_wr_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic [VALUE_W-1:0] m_tdata;
  logic               m_tlast;
  logic               m_tuser;

  inv_word_t inv_q[$];
  longint    lu_cells[64];
  int        row_perm[8];
  int        load_cnt;
  int        order_reg;
  int        filled;
  int        errors;
  int        stall_cnt;
  bit        gaps_on;

  lup_matrix_inverse_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip(longint v);
    if (v > longint'(VAL_MAX)) return longint'(VAL_MAX);
    if (v < longint'(VAL_MIN)) return longint'(VAL_MIN);
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clip((a * b + 32768) >>> 16);
  endfunction

  function automatic longint fx_div(longint a, longint d);
    if (d == 0) return 0;
    return clip((a * 65536) / d);
  endfunction

  // in-place LUP factorization; returns 1 on a zero pivot
  function automatic bit lup_factor(int n);
    longint best, a, t, u, l;
    int pick, tp;
    for (int i = 0; i < n; i++) row_perm[i] = i;
    for (int i = 0; i + 1 < n; i++) begin
      best = 0;
      pick = i;
      for (int j = i; j < n; j++) begin
        a = lu_cells[j*n+i];
        if (a < 0) a = -a;
        if (a > best) begin
          best = a;
          pick = j;
        end
      end
      if (best == 0) return 1'b1;
      tp = row_perm[i]; row_perm[i] = row_perm[pick]; row_perm[pick] = tp;
      for (int k = 0; k < n; k++) begin
        t = lu_cells[i*n+k];
        lu_cells[i*n+k] = lu_cells[pick*n+k];
        lu_cells[pick*n+k] = t;
      end
      u = lu_cells[i*n+i];
      for (int j = i + 1; j < n; j++) begin
        l = fx_div(lu_cells[j*n+i], u);
        lu_cells[j*n+i] = l;
        for (int k = i + 1; k < n; k++)
          lu_cells[j*n+k] = clip(lu_cells[j*n+k] - fx_mul(lu_cells[i*n+k], l));
      end
    end
    return lu_cells[(n-1)*n+(n-1)] == 0;
  endfunction

  task automatic predict_inverse(logic [VALUE_W-1:0] v, logic last);
    int n, cells;
    bit sing;
    longint inv[64];
    longint y[8];
    longint x[8];
    inv_word_t w;
    n = (order_reg < 1) ? 1 : (order_reg > 8) ? 8 : order_reg;
    cells = n * n;
    if (load_cnt < cells) begin
      lu_cells[load_cnt] = longint'($signed(v));
      load_cnt++;
    end
    if (!last) return;
    load_cnt = 0;
    sing = lup_factor(n);
    for (int k = 0; k < cells; k++) inv[k] = 0;
    if (!sing) begin
      for (int c = 0; c < n; c++) begin
        for (int i = 0; i < n; i++) begin
          y[i] = (row_perm[i] == c) ? 65536 : 0;
          for (int j = 0; j < i; j++) y[i] = clip(y[i] - fx_mul(lu_cells[i*n+j], y[j]));
        end
        for (int i = n - 1; i >= 0; i--) begin
          x[i] = y[i];
          for (int j = n - 1; j > i; j--) x[i] = clip(x[i] - fx_mul(lu_cells[i*n+j], x[j]));
          x[i] = fx_div(x[i], lu_cells[i*n+i]);
          inv[i*n+c] = x[i];
        end
      end
    end
    for (int k = 0; k < cells; k++) begin
      w.value = inv[k][VALUE_W-1:0];
      w.last  = (k + 1 == cells);
      w.sing  = sing;
      inv_q.push_back(w);
    end
  endtask

  task automatic report(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    inv_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (inv_q.size() == 0) begin
        report("unexpected word", m_tdata, '0);
      end else begin
        w = inv_q.pop_front();
        if (m_tdata !== w.value) report("value", m_tdata, w.value);
        if (m_tlast !== w.last) report("tlast", VALUE_W'(m_tlast), VALUE_W'(w.last));
        if (m_tuser !== w.sing) report("singular", VALUE_W'(m_tuser), VALUE_W'(w.sing));
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !gaps_on || ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == 40000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [VALUE_W-1:0] v, logic last);
    while (gaps_on && $urandom_range(99) < 33) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = v;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_inverse(v, last);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drain();
    wait (inv_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_order(int n);
    wait_drain();
    cfg_wr_data = n[3:0];
    cfg_wr_en   = 1'b1;
    order_reg   = n;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // flavor: 0 full range, 1 diagonally dominant, 2 small integers, 3 rank one
  function automatic logic [VALUE_W-1:0] pick_elem(int flavor, int r, int c, int n);
    int mag;
    case (flavor)
      0: return $urandom;
      1: begin
        if (r == c) begin
          mag = n * 65536 + $urandom_range(65536);
          return ($urandom_range(1)) ? mag : -mag;
        end
        return $urandom_range(131072) - 65536;
      end
      2: return ($urandom_range(6) - 3) << 16;
      default: return (c + 1) << 16;
    endcase
  endfunction

  task automatic send_matrix(int n, int flavor, int words);
    for (int k = 0; k < words; k++)
      send_word(pick_elem(flavor, (k / n) % n, k % n, n), k == words - 1);
    if (words > filled) filled = words;
  endtask

  task automatic test_reset_order();
    send_matrix(6, 1, 36);
  endtask

  task automatic test_order_one();
    set_order(1);
    send_word(32'h0001_0000, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7fff_ffff, 1'b1);
    send_word(32'h0000_0001, 1'b1);
    send_word(32'h0000_0000, 1'b1);
  endtask

  task automatic test_singular();
    set_order(2);
    send_word(32'h0001_0000, 1'b0); send_word(32'h0001_0000, 1'b0);
    send_word(32'h0001_0000, 1'b0); send_word(32'h0001_0000, 1'b1);
    send_word(32'h0000_0000, 1'b0); send_word(32'h0001_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0); send_word(32'h0002_0000, 1'b1);
  endtask

  task automatic test_overlong();
    send_matrix(2, 2, 6);
  endtask

  task automatic test_short();
    set_order(3);
    send_matrix(3, 0, 4);
  endtask

  task automatic test_clamp();
    set_order(0);
    send_word(32'h0004_0000, 1'b1);
    set_order(15);
    gaps_on = 1'b0;
    send_matrix(8, 1, 64);
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_resize_midload();
    set_order(2);
    send_word(32'h0003_0000, 1'b0);
    send_word(32'h0000_8000, 1'b0);
    set_order(3);
    for (int k = 2; k < 9; k++) send_word(pick_elem(1, k / 3, k % 3, 3), k == 8);
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    gaps_on = 1'b1;
    load_cnt = 0;
    order_reg = 6;
    filled = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_order();
    test_order_one();
    test_singular();
    test_overlong();
    test_short();
    test_clamp();
    test_resize_midload();
    wait (inv_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- lup_matrix_inverse_core.f -----
rtl/core/lupi_pkg.sv
rtl/core/lupi_ram.sv
rtl/core/lupi_div.sv
rtl/core/lup_matrix_inverse_core.sv
bench/tb.sv
